@@ sv/fixed_width_int_field_parser_core_assert.svh @@
// assertion macros shared by the parser core
`ifndef FIXED_WIDTH_INT_FIELD_PARSER_CORE_ASSERT_SVH
`define FIXED_WIDTH_INT_FIELD_PARSER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FWIP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwip check failed");

// antecedent implies consequent in the next cycle
`define FWIP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwip check failed");

`endif

@@ sv/fwip_pkg.sv @@
package fwip_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int CHAR_BITS          = 8;
    localparam int OUT_BITS           = 32;
    localparam int QUEUE_DEPTH        = 2;
    localparam int APB_ADDR_BITS      = 4;
    localparam int APB_DATA_BITS      = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    // register indexes, byte address 4*index
    localparam logic [1:0] REG_FIELD_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FIELD_COUNT  = 2'd1;
    localparam logic [1:0] REG_VALUE_OFFSET = 2'd2;

    localparam logic [7:0]  FIELD_WIDTH_RESET  = 8'd10;
    localparam logic [15:0] FIELD_COUNT_RESET  = 16'd1;
    localparam logic [31:0] VALUE_OFFSET_RESET = 32'd0;

    typedef struct packed {
        logic [7:0]  field_width;
        logic [15:0] field_count;
        logic [31:0] value_offset;
    } fwip_cfg_t;

endpackage

@@ sv/fwip_if.sv @@
interface fwip_char_if import fwip_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface fwip_field_if import fwip_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] field_value;
    logic                       last_field;

    modport source (output valid, output field_value, output last_field, input ready);
    modport sink (input valid, input field_value, input last_field, output ready);
endinterface

@@ sv/fwip_front.sv @@
module fwip_front import fwip_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    fwip_char_if.sink             chars,
    input  fwip_cfg_t             cfg,
    output logic                  push_valid,
    input  logic                  push_ready,
    output logic [VALUE_BITS-1:0] push_value,
    output logic                  push_last
);

    localparam logic [1:0] PHASE_SKIP   = 2'd0;
    localparam logic [1:0] PHASE_DIGITS = 2'd1;
    localparam logic [1:0] PHASE_DONE   = 2'd2;

    logic [1:0]            phase_reg, phase_next, upd_phase;
    logic                  neg_reg, neg_next, upd_neg;
    logic [VALUE_BITS-1:0] acc_reg, acc_next, upd_acc;
    logic [VALUE_BITS-1:0] accn_reg, accn_next, upd_accn;
    logic [7:0]            pos_reg, pos_next, pos_inc;
    logic [15:0]           idx_reg, idx_next, idx_inc;

    logic                  accept, field_end, is_digit, is_sign;
    logic [3:0]            digit;
    logic [VALUE_BITS-1:0] digit_ext, acc_mac, accn_mac;

    assign chars.ready = push_ready;
    assign accept      = chars.valid && push_ready;

    assign is_digit  = (chars.char_code >= CHAR_ZERO) && (chars.char_code <= CHAR_NINE);
    assign is_sign   = (chars.char_code == CHAR_PLUS) || (chars.char_code == CHAR_MINUS);
    assign digit     = 4'(chars.char_code - CHAR_ZERO);
    assign digit_ext = {{(VALUE_BITS-4){1'b0}}, digit};

    // times ten by shift and add; the negated copy runs alongside
    assign acc_mac  = (acc_reg << 3) + (acc_reg << 1) + digit_ext;
    assign accn_mac = (accn_reg << 3) + (accn_reg << 1) - digit_ext;

    always_comb
    begin
        upd_phase = phase_reg;
        upd_neg   = neg_reg;
        upd_acc   = acc_reg;
        upd_accn  = accn_reg;
        unique case (phase_reg)
            PHASE_SKIP:
            begin
                if (is_sign)
                begin
                    upd_neg   = (chars.char_code == CHAR_MINUS);
                    upd_phase = PHASE_DIGITS;
                end
                else if (is_digit)
                begin
                    upd_acc   = acc_mac;
                    upd_accn  = accn_mac;
                    upd_phase = PHASE_DIGITS;
                end
            end
            PHASE_DIGITS:
            begin
                if (is_digit)
                begin
                    upd_acc  = acc_mac;
                    upd_accn = accn_mac;
                end
                else
                begin
                    upd_phase = PHASE_DONE;
                end
            end
            PHASE_DONE:
            begin
                upd_phase = PHASE_DONE;
            end
            default:
            begin
                upd_phase = PHASE_DONE;
            end
        endcase
    end

    // width 0 and count 0 fall out of the wrap of the counters
    assign pos_inc   = pos_reg + 8'd1;
    assign idx_inc   = idx_reg + 16'd1;
    assign field_end = (pos_inc == cfg.field_width);

    assign push_valid = chars.valid && field_end;
    assign push_last  = (idx_inc == cfg.field_count);
    assign push_value = upd_neg ? upd_accn : upd_acc;

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        accn_next  = accn_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        if (accept)
        begin
            if (field_end)
            begin
                phase_next = PHASE_SKIP;
                neg_next   = 1'b0;
                acc_next   = '0;
                accn_next  = '0;
                pos_next   = 8'd0;
                idx_next   = push_last ? 16'd0 : idx_inc;
            end
            else
            begin
                phase_next = upd_phase;
                neg_next   = upd_neg;
                acc_next   = upd_acc;
                accn_next  = upd_accn;
                pos_next   = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_SKIP;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            accn_reg  <= '0;
            pos_reg   <= 8'd0;
            idx_reg   <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            accn_reg  <= accn_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

@@ sv/fwip_queue.sv @@
module fwip_queue import fwip_pkg::*;
#(
    parameter int WIDTH = VALUE_BITS_DEFAULT + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ sv/fwip_back.sv @@
module fwip_back import fwip_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  logic [VALUE_BITS-1:0] pop_value,
    input  logic                  pop_last,
    input  fwip_cfg_t             cfg,
    fwip_field_if.source          fields
);

    logic                valid_reg;
    logic [OUT_BITS-1:0] value_reg, value_next;
    logic                last_reg;
    logic [OUT_BITS-1:0] ext_value;

    // sign-extend or cut the accumulator to the result width
    if (VALUE_BITS >= OUT_BITS)
    begin : g_cut
        assign ext_value = pop_value[OUT_BITS-1:0];
    end
    else
    begin : g_ext
        assign ext_value = {{(OUT_BITS-VALUE_BITS){pop_value[VALUE_BITS-1]}}, pop_value};
    end

    assign value_next = ext_value + cfg.value_offset;
    assign pop_ready  = !valid_reg || fields.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop_ready)
            valid_reg <= pop_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            value_reg <= value_next;
            last_reg  <= pop_last;
        end
    end

    assign fields.valid       = valid_reg;
    assign fields.field_value = value_reg;
    assign fields.last_field  = last_reg;

endmodule

@@ sv/fixed_width_int_field_parser_core.sv @@
// channel   dir  payload                      transfer when
// chars     in   char_code[7:0]               valid && ready
// fields    out  field_value[31:0], last_field valid && ready
// apb       in   field_width, field_count,    psel && penable && pwrite
//                value_offset at 0x0/0x4/0x8
//
// one character per cycle while the queue is not full, set by the shift-add accumulator update
// a result passes from the character ending its field through a queue entry into the output register
// rst_n is asynchronous, active low; restores register defaults and an empty field
// a two-entry queue parts parser and output; chars.ready drops only when it is full
`include "fixed_width_int_field_parser_core_assert.svh"

module fixed_width_int_field_parser_core import fwip_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    fwip_char_if.sink                chars,
    fwip_field_if.source             fields,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    fwip_cfg_t             cfg_reg, cfg_next;
    logic                  cfg_write;
    logic [1:0]            reg_index;

    logic                  push_valid, push_ready, push_last;
    logic [VALUE_BITS-1:0] push_value;
    logic                  pop_valid, pop_ready;
    logic [VALUE_BITS:0]   pop_data;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                REG_FIELD_WIDTH:  cfg_next.field_width  = pwdata[7:0];
                REG_FIELD_COUNT:  cfg_next.field_count  = pwdata[15:0];
                REG_VALUE_OFFSET: cfg_next.value_offset = pwdata[31:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_FIELD_WIDTH:  prdata = {24'd0, cfg_reg.field_width};
            REG_FIELD_COUNT:  prdata = {16'd0, cfg_reg.field_count};
            REG_VALUE_OFFSET: prdata = cfg_reg.value_offset;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_width  <= FIELD_WIDTH_RESET;
            cfg_reg.field_count  <= FIELD_COUNT_RESET;
            cfg_reg.value_offset <= VALUE_OFFSET_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fwip_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_value (push_value),
        .push_last  (push_last)
    );

    fwip_queue #(
        .WIDTH (VALUE_BITS + 1)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_value, push_last}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    fwip_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_value (pop_data[VALUE_BITS:1]),
        .pop_last  (pop_data[0]),
        .cfg       (cfg_reg),
        .fields    (fields)
    );

    // a finished field is in the queue the cycle after its last character
    `FWIP_ASSERT_NXT(a_push_lands, push_valid && push_ready, pop_valid)
    // the back refuses an entry only while its result is stalled
    `FWIP_ASSERT_IMP(a_pop_stall, pop_valid && !pop_ready, fields.valid && !fields.ready)
    // a new result only ever comes from a queue entry
    `FWIP_ASSERT_IMP(a_out_source, $rose(fields.valid), $past(pop_valid))

endmodule
